### rtl/core/brf_pkg.sv
// shared types, constants and the fixed-point f(x) helper for the bisection root finder
package brf_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 24;
  localparam int X_W       = 32;
  localparam int F_W       = 48;
  localparam int TOL_W     = 31;
  localparam int ITER_W    = 6;
  localparam int STATUS_W  = 3;
  localparam int SQ_W      = 2 * X_W;

  // iteration cap, 1 to 64
  localparam int MAX_ITER = 48;
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(MAX_ITER - 1);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16384);

  // row status codes
  localparam logic [STATUS_W-1:0] ST_ITERATING  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FMID_SMALL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WIDTH_STOP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CAP        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_CHANGE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_END_ROOT   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NARROW     = 3'd6;

  // squarer operand select
  localparam logic [1:0] SEL_LEFT  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_MID   = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       fl_en;
    logic       fr_en;
    logic       mid_en;
    logic       fm_en;
    logic       emit_reject;
    logic       emit_row;
  } brf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic reject;
    logic stop;
    logic out_free;
  } brf_sts_t;

  // f(x) = (x*x >> FRAC_BITS) - 2, from the registered square, saturated to F_W bits
  function automatic logic signed [F_W-1:0] f_of_sq(input logic [SQ_W-1:0] sq);
    logic [SQ_W-1:0]      sh;
    logic signed [SQ_W+1:0] r;
    logic signed [SQ_W+1:0] f_max;
    logic signed [SQ_W+1:0] f_min;
    sh    = sq >> FRAC_BITS;
    r     = $signed({2'b00, sh}) - ((SQ_W+2)'(2) <<< FRAC_BITS);
    f_max = (SQ_W+2)'({1'b0, {(F_W-1){1'b1}}});
    f_min = -f_max - (SQ_W+2)'(1);
    if (r > f_max) begin
      return {1'b0, {(F_W-1){1'b1}}};
    end else if (r < f_min) begin
      return {1'b1, {(F_W-1){1'b0}}};
    end else begin
      return r[F_W-1:0];
    end
  endfunction

  // absolute difference of two signed x values
  function automatic logic [X_W-1:0] abs_diff(input logic signed [X_W-1:0] a,
                                               input logic signed [X_W-1:0] b);
    logic signed [X_W:0] d;
    d = (a > b) ? ({a[X_W-1], a} - {b[X_W-1], b}) : ({b[X_W-1], b} - {a[X_W-1], a});
    return d[X_W-1:0];
  endfunction

endpackage

### rtl/core/brf_ctrl.sv
// controller state machine sequencing the bisection datapath
module brf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brf_pkg::brf_sts_t sts_i,
  output brf_pkg::brf_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FA   = 4'd1;
  localparam logic [3:0] S_FB   = 4'd2;
  localparam logic [3:0] S_FR   = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_MID  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_FM   = 4'd7;
  localparam logic [3:0] S_EVAL = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FA;
        end
      end
      S_FA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = brf_pkg::SEL_LEFT;
        state_d       = S_FB;
      end
      S_FB: begin
        cmd_o.fl_en   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = brf_pkg::SEL_RIGHT;
        state_d       = S_FR;
      end
      S_FR: begin
        cmd_o.fr_en = 1'b1;
        state_d     = S_DEC;
      end
      S_DEC: begin
        if (!sts_i.reject) begin
          state_d = S_MID;
        end else if (sts_i.out_free) begin
          cmd_o.emit_reject = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_MID: begin
        cmd_o.mid_en = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = brf_pkg::SEL_MID;
        state_d       = S_FM;
      end
      S_FM: begin
        cmd_o.fm_en = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_row = 1'b1;
          state_d        = sts_i.stop ? S_IDLE : S_MID;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/brf_dp.sv
// datapath: interval registers, shared squarer, stop tests and the output register
module brf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  brf_pkg::brf_cmd_t                    cmd_i,
  output brf_pkg::brf_sts_t                    sts_o,
  input  logic                                 cfg_valid_i,
  input  logic [brf_pkg::TOL_W-1:0]            cfg_tolerance_i,
  input  logic signed [brf_pkg::X_W-1:0]       left_end_i,
  input  logic signed [brf_pkg::X_W-1:0]       right_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [brf_pkg::ITER_W-1:0]           iteration_o,
  output logic signed [brf_pkg::X_W-1:0]       row_left_o,
  output logic signed [brf_pkg::X_W-1:0]       row_right_o,
  output logic signed [brf_pkg::F_W-1:0]       f_left_o,
  output logic signed [brf_pkg::F_W-1:0]       f_right_o,
  output logic signed [brf_pkg::X_W-1:0]       midpoint_o,
  output logic signed [brf_pkg::F_W-1:0]       f_mid_o,
  output logic [brf_pkg::X_W-1:0]              width_o,
  output logic [brf_pkg::STATUS_W-1:0]         status_o,
  output logic                                 last_o
);

  localparam int XW = brf_pkg::X_W;
  localparam int FW = brf_pkg::F_W;

  logic [brf_pkg::TOL_W-1:0]    tol_q;
  logic signed [XW-1:0]         left_q, right_q, mid_q;
  logic signed [FW-1:0]         fl_q, fr_q, fm_q;
  logic [brf_pkg::SQ_W-1:0]     sq_q;
  logic [brf_pkg::ITER_W-1:0]   iter_q;
  logic                         out_valid_q;
  logic [brf_pkg::ITER_W-1:0]   o_iter_q;
  logic signed [XW-1:0]         o_left_q, o_right_q, o_mid_q;
  logic signed [FW-1:0]         o_fl_q, o_fr_q, o_fm_q;
  logic [XW-1:0]                o_width_q;
  logic [brf_pkg::STATUS_W-1:0] o_status_q;
  logic                         o_last_q;

  logic signed [XW-1:0]         mul_op;
  logic [XW-1:0]                mul_mag;
  logic signed [XW:0]           mid_sum;
  logic [XW-1:0]                cur_width;
  logic [XW:0]                  tol_x;
  logic [FW-1:0]                fm_mag;
  logic                         fm_small;
  logic                         go_right;
  logic signed [XW-1:0]         new_left, new_right;
  logic [XW-1:0]                new_width;
  logic                         width_stop;
  logic                         cap_stop;
  logic [brf_pkg::STATUS_W-1:0] row_status;
  logic [brf_pkg::STATUS_W-1:0] rej_status;
  logic                         end_root, same_sign;
  logic                         emit;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= brf_pkg::TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_tolerance_i;
    end
  end

  // squarer: magnitude of the selected operand, one 32x32 product per cycle while mul_en is set
  always_comb begin
    case (cmd_i.mul_sel)
      brf_pkg::SEL_LEFT:  mul_op = left_q;
      brf_pkg::SEL_RIGHT: mul_op = right_q;
      brf_pkg::SEL_MID:   mul_op = mid_q;
      default:            mul_op = mid_q;
    endcase
    mul_mag = mul_op[XW-1] ? (~mul_op + XW'(1)) : mul_op;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      sq_q <= {{XW{1'b0}}, mul_mag} * {{XW{1'b0}}, mul_mag};
    end
  end

  // bolzano check on the endpoint values
  assign cur_width  = brf_pkg::abs_diff(left_q, right_q);
  assign tol_x      = {{(XW + 1 - brf_pkg::TOL_W){1'b0}}, tol_q};
  assign end_root   = (fl_q == '0) || (fr_q == '0);
  assign same_sign  = (fl_q[FW-1] == fr_q[FW-1]);

  always_comb begin
    if (end_root) begin
      rej_status = brf_pkg::ST_END_ROOT;
    end else if (same_sign) begin
      rej_status = brf_pkg::ST_NO_CHANGE;
    end else begin
      rej_status = brf_pkg::ST_NARROW;
    end
  end

  // midpoint, floor of the half sum
  assign mid_sum = {left_q[XW-1], left_q} + {right_q[XW-1], right_q};

  // step evaluation: midpoint test, interval update and the stop reason
  assign fm_mag   = fm_q[FW-1] ? (~fm_q + FW'(1)) : fm_q;
  assign fm_small = (fm_mag < {{(FW - brf_pkg::TOL_W){1'b0}}, tol_q});
  assign go_right = (fl_q[FW-1] && !fm_q[FW-1] && (fm_q != '0)) ||
                    (!fl_q[FW-1] && (fl_q != '0) && fm_q[FW-1]);
  assign new_left   = go_right ? left_q : mid_q;
  assign new_right  = go_right ? mid_q : right_q;
  assign new_width  = brf_pkg::abs_diff(new_left, new_right);
  assign width_stop = ({1'b0, new_width} <= tol_x);
  assign cap_stop   = (iter_q == brf_pkg::LAST_ITER);

  always_comb begin
    if (fm_small) begin
      row_status = brf_pkg::ST_FMID_SMALL;
    end else if (width_stop) begin
      row_status = brf_pkg::ST_WIDTH_STOP;
    end else if (cap_stop) begin
      row_status = brf_pkg::ST_CAP;
    end else begin
      row_status = brf_pkg::ST_ITERATING;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q  <= left_end_i;
      right_q <= right_end_i;
    end else if (cmd_i.emit_row && !fm_small) begin
      left_q  <= new_left;
      right_q <= new_right;
    end
    if (cmd_i.fl_en) begin
      fl_q <= brf_pkg::f_of_sq(sq_q);
    end else if (cmd_i.emit_row && !fm_small && !go_right) begin
      fl_q <= fm_q;
    end
    if (cmd_i.fr_en) begin
      fr_q <= brf_pkg::f_of_sq(sq_q);
    end else if (cmd_i.emit_row && !fm_small && go_right) begin
      fr_q <= fm_q;
    end
    if (cmd_i.mid_en) begin
      mid_q <= mid_sum[XW:1];
    end
    if (cmd_i.fm_en) begin
      fm_q <= brf_pkg::f_of_sq(sq_q);
    end
  end

  // row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.load) begin
      iter_q <= '0;
    end else if (cmd_i.emit_row) begin
      iter_q <= iter_q + brf_pkg::ITER_W'(1);
    end
  end

  // output register, filled when empty or drained in the same cycle
  assign emit = cmd_i.emit_row || cmd_i.emit_reject;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_iter_q  <= iter_q;
      o_left_q  <= left_q;
      o_right_q <= right_q;
      o_fl_q    <= fl_q;
      o_fr_q    <= fr_q;
      o_width_q <= cur_width;
      if (cmd_i.emit_reject) begin
        o_mid_q    <= '0;
        o_fm_q     <= '0;
        o_status_q <= rej_status;
        o_last_q   <= 1'b1;
      end else begin
        o_mid_q    <= mid_q;
        o_fm_q     <= fm_q;
        o_status_q <= row_status;
        o_last_q   <= (row_status != brf_pkg::ST_ITERATING);
      end
    end
  end

  // status to the controller
  assign sts_o.reject   = end_root || same_sign || ({1'b0, cur_width} <= tol_x);
  assign sts_o.stop     = (row_status != brf_pkg::ST_ITERATING);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign iteration_o = o_iter_q;
  assign row_left_o  = o_left_q;
  assign row_right_o = o_right_q;
  assign f_left_o    = o_fl_q;
  assign f_right_o   = o_fr_q;
  assign midpoint_o  = o_mid_q;
  assign f_mid_o     = o_fm_q;
  assign width_o     = o_width_q;
  assign status_o    = o_status_q;
  assign last_o      = o_last_q;

endmodule

### rtl/core/bisection_root_finder_core.sv
// top level of the bisection root finder for f(x) = x*x - 2 in fixed point
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   left_end_i, right_end_i (Q8.24)
//   out      out_valid_o / out_ready_i iteration_o .. last_o, one row per step
//   cfg      cfg_valid_i / cfg_ready_o cfg_tolerance_i (unsigned Q7.24, 31 bits)
//
// one search at a time: endpoint evaluation and sign check (states FA, FB, FR,
// DEC), then one emitted row per step of midpoint, square, f value and evaluate
// (states MID, MUL, FM, EVAL), all sharing the single 32x32 squarer.
// a finished row sits in the output register while the next step is worked on;
// a stalled output holds the controller in its decide or evaluate state.
// reset clears the controller, the output valid and sets tolerance to 16384.
module bisection_root_finder_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [brf_pkg::X_W-1:0]       left_end_i,
  input  logic signed [brf_pkg::X_W-1:0]       right_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [brf_pkg::ITER_W-1:0]           iteration_o,
  output logic signed [brf_pkg::X_W-1:0]       row_left_o,
  output logic signed [brf_pkg::X_W-1:0]       row_right_o,
  output logic signed [brf_pkg::F_W-1:0]       f_left_o,
  output logic signed [brf_pkg::F_W-1:0]       f_right_o,
  output logic signed [brf_pkg::X_W-1:0]       midpoint_o,
  output logic signed [brf_pkg::F_W-1:0]       f_mid_o,
  output logic [brf_pkg::X_W-1:0]              width_o,
  output logic [brf_pkg::STATUS_W-1:0]         status_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [brf_pkg::TOL_W-1:0]            cfg_tolerance_i
);

  brf_pkg::brf_cmd_t cmd;
  brf_pkg::brf_sts_t sts;

  // tolerance writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  brf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath and output register
  brf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_tolerance_i (cfg_tolerance_i),
    .left_end_i      (left_end_i),
    .right_end_i     (right_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .iteration_o     (iteration_o),
    .row_left_o      (row_left_o),
    .row_right_o     (row_right_o),
    .f_left_o        (f_left_o),
    .f_right_o       (f_right_o),
    .midpoint_o      (midpoint_o),
    .f_mid_o         (f_mid_o),
    .width_o         (width_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while search still running");

  // a pending row that is not the last one means the search is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("controller idle with an unfinished search");

  // rejection codes only appear on the first row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (iteration_o != '0) |->
      (status_o != brf_pkg::ST_NO_CHANGE) && (status_o != brf_pkg::ST_END_ROOT) &&
      (status_o != brf_pkg::ST_NARROW))
    else $error("rejection status on a later row");

endmodule

### dv/brf_row_checker.sv
// checker for the bisection root finder: predicts every log row and compares it with the output
module brf_row_checker
  import brf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [X_W-1:0]      left_end_i,
  input  logic signed [X_W-1:0]      right_end_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [ITER_W-1:0]          iteration_i,
  input  logic signed [X_W-1:0]      row_left_i,
  input  logic signed [X_W-1:0]      row_right_i,
  input  logic signed [F_W-1:0]      f_left_i,
  input  logic signed [F_W-1:0]      f_right_i,
  input  logic signed [X_W-1:0]      midpoint_i,
  input  logic signed [F_W-1:0]      f_mid_i,
  input  logic [X_W-1:0]             width_i,
  input  logic [STATUS_W-1:0]        status_i,
  input  logic                       last_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [TOL_W-1:0]           cfg_tolerance_i,
  output int                         fails_o,
  output int                         pending_o,
  output int                         intervals_o,
  output int                         rows_o,
  output int                         stop_seen_o [7]
);
  timeunit 1ns;
  timeprecision 1ps;

  // saturation bounds of a Q24.24 f value
  localparam longint F_TOP = (longint'(1) <<< (F_W - 1)) - 1;
  localparam longint F_BOT = -F_TOP - 1;

  typedef struct {
    logic [ITER_W-1:0]     iteration;
    logic signed [X_W-1:0] row_left;
    logic signed [X_W-1:0] row_right;
    logic signed [F_W-1:0] f_left;
    logic signed [F_W-1:0] f_right;
    logic signed [X_W-1:0] midpoint;
    logic signed [F_W-1:0] f_mid;
    logic [X_W-1:0]        width;
    logic [STATUS_W-1:0]   status;
    logic                  last;
  } log_row_t;

  log_row_t          rows_due[$];
  logic [TOL_W-1:0]  tolerance;
  log_row_t          want;

  // f(x) = x*x - 2 with the square truncated to the x fraction, saturated to 48 bits
  function automatic logic signed [F_W-1:0] square_less_two(input logic signed [X_W-1:0] x);
    logic [X_W-1:0]             mag;
    logic [2*X_W-1:0]           sq;
    logic signed [2*X_W+1:0]    r;
    mag = x[X_W-1] ? -x : x;
    sq  = {{X_W{1'b0}}, mag} * {{X_W{1'b0}}, mag};
    r   = $signed({2'b00, sq >> FRAC_BITS}) - ((2*X_W+2)'(2) <<< FRAC_BITS);
    if (r > F_TOP) begin
      return F_W'(F_TOP);
    end else if (r < F_BOT) begin
      return F_W'(F_BOT);
    end
    return r[F_W-1:0];
  endfunction

  // floor of the mean, computed one bit wider
  function automatic logic signed [X_W-1:0] halfway(input logic signed [X_W-1:0] a,
                                                     input logic signed [X_W-1:0] b);
    logic signed [X_W:0] sum;
    sum = {a[X_W-1], a} + {b[X_W-1], b};
    return sum[X_W:1];
  endfunction

  // interval width, either orientation
  function automatic logic [X_W-1:0] span(input logic signed [X_W-1:0] a,
                                          input logic signed [X_W-1:0] b);
    logic signed [X_W:0] d;
    d = $signed({a[X_W-1], a}) - $signed({b[X_W-1], b});
    if (d < 0) begin
      d = -d;
    end
    return d[X_W-1:0];
  endfunction

  function automatic bit narrow_enough(input logic [X_W-1:0] w);
    return longint'(w) <= longint'(tolerance);
  endfunction

  function automatic log_row_t log_row(input int n, input logic signed [X_W-1:0] a, b,
                                       input logic signed [F_W-1:0] fa, fb,
                                       input logic signed [X_W-1:0] mid,
                                       input logic signed [F_W-1:0] fm,
                                       input logic [STATUS_W-1:0] st, input logic fin);
    log_row_t row;
    row.iteration = ITER_W'(n);
    row.row_left  = a;
    row.row_right = b;
    row.f_left    = fa;
    row.f_right   = fb;
    row.midpoint  = mid;
    row.f_mid     = fm;
    row.width     = span(a, b);
    row.status    = st;
    row.last      = fin;
    return row;
  endfunction

  // run the whole search for one interval and queue every row it logs
  task automatic predict_search(input logic signed [X_W-1:0] a0, b0);
    logic signed [X_W-1:0] a;
    logic signed [X_W-1:0] b;
    logic signed [X_W-1:0] mid;
    logic signed [F_W-1:0] fa;
    logic signed [F_W-1:0] fb;
    logic signed [F_W-1:0] fm;
    longint                fm_mag;
    log_row_t              row;
    int                    n;
    bit                    done;
    a  = a0;
    b  = b0;
    fa = square_less_two(a);
    fb = square_less_two(b);
    if (fa == 0 || fb == 0 || ((fa < 0) == (fb < 0))) begin
      rows_due.push_back(log_row(0, a, b, fa, fb, '0, '0,
                                 (fa == 0 || fb == 0) ? ST_END_ROOT : ST_NO_CHANGE, 1'b1));
    end else if (narrow_enough(span(a, b))) begin
      rows_due.push_back(log_row(0, a, b, fa, fb, '0, '0, ST_NARROW, 1'b1));
    end else begin
      n    = 0;
      done = 1'b0;
      while (!done) begin
        mid    = halfway(a, b);
        fm     = square_less_two(mid);
        fm_mag = (fm < 0) ? -longint'(fm) : longint'(fm);
        row    = log_row(n, a, b, fa, fb, mid, fm, ST_ITERATING, 1'b0);
        n++;
        if (fm_mag < longint'(tolerance)) begin
          // midpoint is close enough, interval stays as it is
          row.status = ST_FMID_SMALL;
          row.last   = 1'b1;
          done       = 1'b1;
        end else begin
          // keep the half with the sign change; a zero midpoint moves the left end
          if ((fa < 0 && fm > 0) || (fa > 0 && fm < 0)) begin
            b  = mid;
            fb = fm;
          end else begin
            a  = mid;
            fa = fm;
          end
          if (narrow_enough(span(a, b))) begin
            row.status = ST_WIDTH_STOP;
            row.last   = 1'b1;
            done       = 1'b1;
          end else if (n >= MAX_ITER) begin
            row.status = ST_CAP;
            row.last   = 1'b1;
            done       = 1'b1;
          end
        end
        rows_due.push_back(row);
      end
    end
  endtask

  function automatic void check_field(input string name, input longint expv, input longint gotv);
    if (expv != gotv) begin
      $error("row field %s: expected %0d, got %0d", name, expv, gotv);
      fails_o++;
    end
  endfunction

  // follow the three channels; predictions are queued at the input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance   <= TOL_RESET;
      rows_due.delete();
      fails_o     = 0;
      intervals_o = 0;
      rows_o      = 0;
      foreach (stop_seen_o[s]) begin
        stop_seen_o[s] = 0;
      end
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        tolerance <= cfg_tolerance_i;
      end
      if (in_valid_i && in_ready_i) begin
        predict_search(left_end_i, right_end_i);
        intervals_o++;
      end
      if (out_valid_i && out_ready_i) begin
        rows_o++;
        if (rows_due.size() == 0) begin
          $error("log row transfer with no row expected (iteration %0d)", iteration_i);
          fails_o++;
        end else begin
          want = rows_due.pop_front();
          stop_seen_o[want.status]++;
          check_field("iteration", want.iteration, iteration_i);
          check_field("row_left",  want.row_left,  row_left_i);
          check_field("row_right", want.row_right, row_right_i);
          check_field("f_left",    want.f_left,    f_left_i);
          check_field("f_right",   want.f_right,   f_right_i);
          check_field("midpoint",  want.midpoint,  midpoint_i);
          check_field("f_mid",     want.f_mid,     f_mid_i);
          check_field("width",     want.width,     width_i);
          check_field("status",    want.status,    status_i);
          check_field("last",      want.last,      last_i);
        end
      end
      pending_o <= rows_due.size();
    end
  end

endmodule

### dv/tb.sv
// testbench top for the bisection root finder: stimulus, flow control and the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEMS_PER_RUN = 67;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE        = 16;

  // nearest Q8.24 codes on each side of sqrt(2)
  localparam logic signed [X_W-1:0] SQRT2_BELOW = 32'sd23726566;
  localparam logic signed [X_W-1:0] SQRT2_ABOVE = 32'sd23726567;
  localparam logic signed [X_W-1:0] X_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [X_W-1:0] X_MIN       = 32'sh8000_0000;
  localparam logic signed [X_W-1:0] X_ONE       = 32'sh0100_0000;
  localparam logic signed [X_W-1:0] X_TWO       = 32'sh0200_0000;
  localparam logic [TOL_W-1:0]      TOL_MAX     = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [X_W-1:0] left_end = '0;
  logic signed [X_W-1:0] right_end = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ITER_W-1:0]     iteration;
  logic signed [X_W-1:0] row_left;
  logic signed [X_W-1:0] row_right;
  logic signed [F_W-1:0] f_left;
  logic signed [F_W-1:0] f_right;
  logic signed [X_W-1:0] midpoint;
  logic signed [F_W-1:0] f_mid;
  logic [X_W-1:0]        width;
  logic [STATUS_W-1:0]   status;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [TOL_W-1:0]      cfg_tolerance = '0;

  int tx_idle_pct = 9;
  int rx_stall_pct = 79;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  int fails;
  int pending;
  int intervals;
  int rows;
  int stop_seen [7];

  bisection_root_finder_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .left_end_i      (left_end),
    .right_end_i     (right_end),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .iteration_o     (iteration),
    .row_left_o      (row_left),
    .row_right_o     (row_right),
    .f_left_o        (f_left),
    .f_right_o       (f_right),
    .midpoint_o      (midpoint),
    .f_mid_o         (f_mid),
    .width_o         (width),
    .status_o        (status),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_tolerance_i (cfg_tolerance)
  );

  brf_row_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .left_end_i      (left_end),
    .right_end_i     (right_end),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .iteration_i     (iteration),
    .row_left_i      (row_left),
    .row_right_i     (row_right),
    .f_left_i        (f_left),
    .f_right_i       (f_right),
    .midpoint_i      (midpoint),
    .f_mid_i         (f_mid),
    .width_i         (width),
    .status_i        (status),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_tolerance_i (cfg_tolerance),
    .fails_o         (fails),
    .pending_o       (pending),
    .intervals_o     (intervals),
    .rows_o          (rows),
    .stop_seen_o     (stop_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // row receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one interval, returns at the edge of its transfer
  task automatic send_interval(input logic signed [X_W-1:0] a, b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    left_end  <= a;
    right_end <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering until every predicted row has been seen, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] tol);
    cfg_valid     <= 1'b1;
    cfg_tolerance <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly bracketing intervals around +-sqrt(2), some tight, some raw noise
  task automatic pick_interval(output logic signed [X_W-1:0] a, b);
    logic signed [X_W-1:0] inner;
    logic signed [X_W-1:0] outer;
    logic signed [X_W-1:0] tmp;
    logic [X_W-1:0]        hi;
    int                    kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      a = $urandom;
      b = $urandom;
    end else begin
      if (kind < 40) begin
        inner = SQRT2_BELOW - $urandom_range(1 << $urandom_range(20, 0));
        outer = SQRT2_ABOVE + $urandom_range(1 << $urandom_range(20, 0));
      end else begin
        hi    = $urandom_range(1) ? X_MAX : SQRT2_ABOVE + (32'd1 << $urandom_range(26, 4));
        inner = $urandom_range(SQRT2_BELOW, 0);
        outer = $urandom_range(hi, SQRT2_ABOVE);
      end
      if ($urandom_range(1)) begin
        inner = -inner;
      end
      if ($urandom_range(1)) begin
        outer = -outer;
      end
      a = inner;
      b = outer;
      if ($urandom_range(1)) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
    end
  endtask

  task automatic run_segment(input logic [TOL_W-1:0] tol, input int tx_pct, input int rx_pct,
                             input bit long_hold);
    logic signed [X_W-1:0] a;
    logic signed [X_W-1:0] b;
    wait_drained();
    write_tolerance(tol);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    if (long_hold) begin
      hold_reqs <= hold_reqs + 1;
    end
    for (int k = 0; k < ITEMS_PER_RUN; k++) begin
      // halfway through, pause the sender until the output side catches up
      if (k == ITEMS_PER_RUN / 2) begin
        wait_drained();
      end
      pick_interval(a, b);
      send_interval(a, b);
    end
  endtask

  // run limit
  initial begin
    #20ms;
    $display("[bisection_root_finder_core] ERROR");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed intervals at the reset tolerance
    send_interval(32'sd0, X_TWO);
    send_interval(X_MIN, X_MAX);
    send_interval(32'sd0, 32'sd0);
    send_interval(X_MAX, 32'sd0);
    send_interval(X_MIN, 32'sd0);
    send_interval(SQRT2_BELOW, SQRT2_ABOVE);
    send_interval(-SQRT2_ABOVE, -SQRT2_BELOW);
    send_interval(SQRT2_ABOVE, SQRT2_ABOVE);
    send_interval(SQRT2_BELOW - 100000, SQRT2_ABOVE + 100000);
    send_interval(-32'sd1, X_MAX);
    send_interval(X_MAX, X_MIN);
    send_interval(X_ONE, -X_TWO);
    send_interval(SQRT2_BELOW, SQRT2_BELOW + 16384);
    send_interval(SQRT2_BELOW, SQRT2_BELOW + 16385);
    send_interval(-32'sd1, 32'sd0);

    // zero tolerance: searches run into the iteration cap, some with a stuck midpoint
    wait_drained();
    write_tolerance('0);
    send_interval(32'sd0, X_MAX);
    send_interval(SQRT2_BELOW, SQRT2_ABOVE);
    send_interval(X_TWO, 32'sd0);

    // random intervals under several tolerances and flow-control mixes
    run_segment('0, 9, 79, 1'b0);
    run_segment(TOL_W'($urandom_range(TOL_MAX) >> $urandom_range(30, 0)), 9, 79, 1'b0);
    run_segment(TOL_MAX, 79, 9, 1'b0);
    run_segment(TOL_RESET, 79, 9, 1'b0);
    run_segment(TOL_W'($urandom_range(TOL_MAX) >> $urandom_range(30, 0)), 0, 0, 1'b1);
    run_segment(TOL_W'(1), 0, 0, 1'b0);
    wait_drained();

    $display("checked %0d intervals and %0d log rows under several tolerance settings",
             intervals, rows);
    $display("stop reasons: fmid %0d, width %0d, cap %0d, no change %0d, end root %0d, narrow %0d",
             stop_seen[ST_FMID_SMALL], stop_seen[ST_WIDTH_STOP], stop_seen[ST_CAP],
             stop_seen[ST_NO_CHANGE], stop_seen[ST_END_ROOT], stop_seen[ST_NARROW]);
    if (fails == 0) begin
      $display("[bisection_root_finder_core] OK");
    end else begin
      $display("[bisection_root_finder_core] ERROR");
    end
    $finish;
  end

endmodule

### bisection_root_finder_core.f
rtl/core/brf_pkg.sv
rtl/core/brf_ctrl.sv
rtl/core/brf_dp.sv
rtl/core/bisection_root_finder_core.sv
dv/brf_row_checker.sv
dv/tb.sv
